/* src/crc_frame_parser_resync_defines.svh */
// assertion macros for the crc frame parser
`ifndef CRC_FRAME_PARSER_RESYNC_DEFINES_SVH
`define CRC_FRAME_PARSER_RESYNC_DEFINES_SVH

// antecedent holds in the same cycle as the consequent
`define CFPR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfpr assertion failed");

// consequent holds in the cycle after the antecedent
`define CFPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfpr assertion failed");

`endif

/* src/cfpr_pkg.sv */
// shared types and constants for the crc frame parser
`timescale 1ns / 1ps

package cfpr_pkg;

  localparam int unsigned FRAME_BYTES = 8;
  localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
  localparam int unsigned CRC_SPAN    = 6;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_MSB     = 16'h8000;
  localparam logic [7:0]  START_RESET = 8'hAA;

  typedef enum logic [1:0] {
    STATUS_NONE   = 2'd0,
    STATUS_FRAME  = 2'd1,
    STATUS_REJECT = 2'd2
  } status_e;

  // control from the sequencer to the crc unit
  typedef struct packed {
    logic clear;
    logic step;
  } crc_ctrl_t;

endpackage

/* src/cfpr_crc.sv */
// byte-wide crc-16 update unit, shared over the six covered bytes
`timescale 1ns / 1ps

module cfpr_crc
  import cfpr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  crc_ctrl_t  ctrl_i,
  input  logic [7:0] data_i,
  output logic [15:0] crc_o
);

  logic [15:0] crc_q;
  logic [15:0] crc_d;
  logic [15:0] upd;

  // one byte through the polynomial, msb first
  always_comb begin
    upd = crc_q ^ {data_i, 8'h00};
    for (int b = 0; b < 8; b++) begin
      if ((upd & CRC_MSB) != 16'h0000) begin
        upd = {upd[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        upd = {upd[14:0], 1'b0};
      end
    end
    if (ctrl_i.clear) begin
      crc_d = CRC_INIT;
    end else if (ctrl_i.step) begin
      crc_d = upd;
    end else begin
      crc_d = crc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
    end else begin
      crc_q <= crc_d;
    end
  end

  assign crc_o = crc_q;

endmodule

/* src/crc_frame_parser_resync.sv */
// Framed byte receiver: bytes before a start byte are dropped, then eight bytes are
// collected (start, command, four data bytes, crc-16/ccitt-false over the first six,
// low byte first). Every accepted byte yields exactly one result: status 0 while
// collecting, 1 with the frame fields when a frame checks, 2 when it fails and the
// buffer slides to the next start byte inside it. An ordinary byte is accepted while the
// block is idle, and its result sits in an output register; a result that is still waiting
// holds off the next byte until the cycle in which that result transfers. After the byte
// that completes a frame, the buffer rotates past the byte-wide crc unit, one check step
// follows, on a reject the buffer shifts once per searched position, and then the result
// is loaded, which waits for as long as the output register is stalled.
`timescale 1ns / 1ps

`include "crc_frame_parser_resync_defines.svh"

module crc_frame_parser_resync
  import cfpr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // received bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [7:0]  command_o,
  output logic [7:0]  payload0_o,
  output logic [7:0]  payload1_o,
  output logic [7:0]  payload2_o,
  output logic [7:0]  payload3_o,
  output logic [15:0] check_value_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_CHECK,
    ST_SHIFT,
    ST_EMIT
  } state_e;

  state_e          state_q;
  logic [3:0]      fill_q;
  logic [IDX_W-1:0] cnt_q;
  status_e         res_status_q;
  logic [7:0]      start_q;
  logic [7:0]      buf_q [FRAME_BYTES];

  logic            out_valid_q;
  logic [1:0]      status_q;
  logic [7:0]      command_q;
  logic [7:0]      payload0_q;
  logic [7:0]      payload1_q;
  logic [7:0]      payload2_q;
  logic [7:0]      payload3_q;
  logic [15:0]     check_value_q;

  logic            in_xfer;
  logic            slot_free;
  logic            last_byte;
  logic            frame_good;
  logic            res_load;
  crc_ctrl_t       crc_ctrl;
  logic [15:0]     crc_val;

  // configuration register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RESET;
    end else if (cfg_valid_i) begin
      start_q <= cfg_data_i;
    end
  end

  // handshake and decode
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign last_byte  = (fill_q == 4'(FRAME_BYTES - 1));
  assign frame_good = (buf_q[0] == start_q) &&
                      (crc_val == {buf_q[FRAME_BYTES-1], buf_q[FRAME_BYTES-2]});
  assign res_load   = (in_xfer && !last_byte) || ((state_q == ST_EMIT) && slot_free);

  // crc unit control
  assign crc_ctrl.clear = in_xfer && last_byte;
  assign crc_ctrl.step  = (state_q == ST_CRC) && (cnt_q < IDX_W'(CRC_SPAN));

  cfpr_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (crc_ctrl),
    .data_i (buf_q[0]),
    .crc_o  (crc_val)
  );

  // frame buffer: fill at the count, rotate for the crc pass, slide on resync
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && !fill_q[3]) begin
          if (fill_q == 4'd0) begin
            if (rx_byte_i == start_q) begin
              buf_q[0] <= rx_byte_i;
            end
          end else begin
            buf_q[fill_q[IDX_W-1:0]] <= rx_byte_i;
          end
        end
      end
      ST_CRC: begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
          buf_q[i] <= buf_q[i+1];
        end
        buf_q[FRAME_BYTES-1] <= buf_q[0];
      end
      ST_SHIFT: begin
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
          buf_q[i] <= buf_q[i+1];
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      fill_q        <= 4'd0;
      cnt_q         <= '0;
      res_status_q  <= STATUS_NONE;
      out_valid_q   <= 1'b0;
      status_q      <= STATUS_NONE;
      command_q     <= 8'h00;
      payload0_q    <= 8'h00;
      payload1_q    <= 8'h00;
      payload2_q    <= 8'h00;
      payload3_q    <= 8'h00;
      check_value_q <= 16'h0000;
    end else begin
      // result register valid: set on load, cleared on transfer
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            if (last_byte) begin
              cnt_q   <= '0;
              state_q <= ST_CRC;
            end else begin
              // count out of range drops the byte and reports a reject
              status_q      <= fill_q[3] ? STATUS_REJECT : STATUS_NONE;
              command_q     <= 8'h00;
              payload0_q    <= 8'h00;
              payload1_q    <= 8'h00;
              payload2_q    <= 8'h00;
              payload3_q    <= 8'h00;
              check_value_q <= 16'h0000;
              if (fill_q[3]) begin
                fill_q <= 4'd0;
              end else if (fill_q == 4'd0) begin
                if (rx_byte_i == start_q) begin
                  fill_q <= 4'd1;
                end
              end else begin
                fill_q <= fill_q + 4'd1;
              end
            end
          end
        end
        ST_CRC: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == IDX_W'(FRAME_BYTES - 1)) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (frame_good) begin
            fill_q       <= 4'd0;
            res_status_q <= STATUS_FRAME;
            state_q      <= ST_EMIT;
          end else begin
            cnt_q        <= IDX_W'(FRAME_BYTES - 1);
            res_status_q <= STATUS_REJECT;
            state_q      <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          // the byte moving into slot zero decides whether to stop here
          if (buf_q[1] == start_q) begin
            fill_q  <= {1'b0, cnt_q};
            state_q <= ST_EMIT;
          end else if (cnt_q == IDX_W'(1)) begin
            fill_q  <= 4'd0;
            state_q <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            status_q <= res_status_q;
            if (res_status_q == STATUS_FRAME) begin
              command_q     <= buf_q[1];
              payload0_q    <= buf_q[2];
              payload1_q    <= buf_q[3];
              payload2_q    <= buf_q[4];
              payload3_q    <= buf_q[5];
              check_value_q <= {buf_q[7], buf_q[6]};
            end else begin
              command_q     <= 8'h00;
              payload0_q    <= 8'h00;
              payload1_q    <= 8'h00;
              payload2_q    <= 8'h00;
              payload3_q    <= 8'h00;
              check_value_q <= 16'h0000;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign command_o     = command_q;
  assign payload0_o    = payload0_q;
  assign payload1_o    = payload1_q;
  assign payload2_o    = payload2_q;
  assign payload3_o    = payload3_q;
  assign check_value_o = check_value_q;

  // checks on the sequencer and result register
  `CFPR_ASSERT_SAME(a_fill_in_range, 1'b1, !fill_q[3])
  `CFPR_ASSERT_NEXT(a_busy_after_last, in_xfer && last_byte, !in_ready_o && !crc_ctrl.clear)
  `CFPR_ASSERT_SAME(a_status_code, out_valid_o,
                    (status_o == STATUS_NONE) || (status_o == STATUS_FRAME) ||
                    (status_o == STATUS_REJECT))
  `CFPR_ASSERT_SAME(a_fields_zero, out_valid_o && (status_o != STATUS_FRAME),
                    (command_o == 8'h00) && (check_value_o == 16'h0000))

endmodule

/* test/tb.sv */
// testbench for the crc frame parser: directed table, random frame traffic, running predictor
`timescale 1ns / 1ps

module tb;
  import cfpr_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned PHASE_BYTES   = 335;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned MAX_PRINTS    = 20;

  typedef struct packed {
    status_e     status;
    logic [7:0]  command;
    logic [7:0]  payload0;
    logic [7:0]  payload1;
    logic [7:0]  payload2;
    logic [7:0]  payload3;
    logic [15:0] check_value;
  } frame_result_t;

  // one row of the directed table: a byte transfer or a start byte write
  typedef struct {
    bit         is_cfg;
    logic [7:0] data;
    bit         typed;
    status_e    want;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  status_o;
  logic [7:0]  command_o;
  logic [7:0]  payload0_o;
  logic [7:0]  payload1_o;
  logic [7:0]  payload2_o;
  logic [7:0]  payload3_o;
  logic [15:0] check_value_o;

  // typed expectation carried alongside the byte of a directed row
  bit      row_typed;
  status_e row_status;

  // predictor state
  logic [7:0] start_model;
  logic [7:0] held_bytes [FRAME_BYTES];
  int         held_count;

  frame_result_t pending_results [$];
  stim_row_t     directed_rows [$];

  int mismatches;
  int results_seen;
  int frames_passed;
  int frames_rejected;
  int bytes_sent;
  int start_writes;
  int burst_left;

  crc_frame_parser_resync dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .command_o     (command_o),
    .payload0_o    (payload0_o),
    .payload1_o    (payload1_o),
    .payload2_o    (payload2_o),
    .payload3_o    (payload3_o),
    .check_value_o (check_value_o)
  );

  // crc-16/ccitt-false over the first six bytes of a frame
  function automatic logic [15:0] crc16_span(input logic [7:0] f [FRAME_BYTES]);
    logic [15:0] c;
    c = CRC_INIT;
    for (int i = 0; i < CRC_SPAN; i++) begin
      c = c ^ {f[i], 8'h00};
      for (int j = 0; j < 8; j++) begin
        c = ((c & CRC_MSB) != 16'h0) ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
    end
    return c;
  endfunction

  // fill in the trailing check bytes, low byte first
  function automatic void seal_frame(inout logic [7:0] f [FRAME_BYTES]);
    logic [15:0] c;
    c = crc16_span(f);
    f[6] = c[7:0];
    f[7] = c[15:8];
  endfunction

  // predictor: advance the parser by one received byte
  function automatic frame_result_t parse_byte(input logic [7:0] rx);
    frame_result_t r;
    int            nxt;
    logic [15:0]   got;
    r = '0;
    r.status = STATUS_NONE;
    if (held_count >= FRAME_BYTES) begin
      held_count = 0;
      r.status = STATUS_REJECT;
      return r;
    end
    if (held_count == 0) begin
      if (rx == start_model) begin
        held_bytes[0] = rx;
        held_count = 1;
      end
      return r;
    end
    held_bytes[held_count] = rx;
    held_count++;
    if (held_count < FRAME_BYTES) return r;
    got = {held_bytes[7], held_bytes[6]};
    if (held_bytes[0] == start_model && crc16_span(held_bytes) == got) begin
      r.status      = STATUS_FRAME;
      r.command     = held_bytes[1];
      r.payload0    = held_bytes[2];
      r.payload1    = held_bytes[3];
      r.payload2    = held_bytes[4];
      r.payload3    = held_bytes[5];
      r.check_value = got;
      held_count = 0;
      return r;
    end
    // resync to the next start byte inside the buffer
    nxt = 1;
    while (nxt < FRAME_BYTES && held_bytes[nxt] != start_model) nxt++;
    if (nxt < FRAME_BYTES) begin
      held_count = FRAME_BYTES - nxt;
      for (int k = 0; k < held_count; k++) held_bytes[k] = held_bytes[k + nxt];
    end else begin
      held_count = 0;
    end
    r.status = STATUS_REJECT;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("mismatch on %s at result %0d: got %0h, want %0h", what, results_seen, got,
               want);
    end
  endtask

  function automatic void add_row(input bit is_cfg, input logic [7:0] data, input bit typed,
                                  input status_e want);
    stim_row_t row;
    row.is_cfg = is_cfg;
    row.data   = data;
    row.typed  = typed;
    row.want   = want;
    directed_rows.push_back(row);
  endfunction

  // directed table: ignored bytes after reset, a good frame of extreme bytes,
  // a bad check with resync, and start byte changes while a frame is held
  function automatic void load_directed_table();
    logic [7:0] f [FRAME_BYTES];
    add_row(0, 8'h00, 1, STATUS_NONE);
    add_row(0, 8'hFF, 1, STATUS_NONE);
    f = '{START_RESET, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00};
    seal_frame(f);
    for (int k = 0; k < FRAME_BYTES - 1; k++) add_row(0, f[k], 1, STATUS_NONE);
    add_row(0, f[7], 0, STATUS_NONE);
    f = '{START_RESET, 8'h5A, START_RESET, 8'h00, 8'hFF, 8'h12, 8'h00, 8'h00};
    seal_frame(f);
    f[6] = f[6] ^ 8'h01;
    for (int k = 0; k < FRAME_BYTES - 1; k++) add_row(0, f[k], 1, STATUS_NONE);
    add_row(0, f[7], 1, STATUS_REJECT);
    // six bytes held, first byte no longer matches the start byte
    add_row(1, 8'hFF, 0, STATUS_NONE);
    add_row(0, 8'h33, 1, STATUS_NONE);
    add_row(0, 8'h44, 1, STATUS_REJECT);
    add_row(1, 8'h00, 0, STATUS_NONE);
    add_row(0, 8'h00, 1, STATUS_NONE);
    add_row(0, 8'h00, 1, STATUS_REJECT);
  endfunction

  // one byte transfer, sender works in bursts with gaps between them
  task automatic send_rx(input logic [7:0] b, input bit typed, input status_e want);
    int gap;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    row_typed  <= typed;
    row_status <= want;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    bytes_sent++;
  endtask

  // start byte write, only once every result is out and the block has settled
  task automatic write_start(input logic [7:0] v);
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    start_writes++;
  endtask

  // send a frame: intact, with one flipped bit, or cut short
  task automatic send_frame(input logic [7:0] sb, input int kind, inout int sent);
    logic [7:0] f [FRAME_BYTES];
    int         n;
    int         bit_sel;
    f[0] = sb;
    for (int k = 1; k < FRAME_BYTES; k++) f[k] = 8'($urandom_range(0, 255));
    seal_frame(f);
    n = FRAME_BYTES;
    if (kind == 1) begin
      n = $urandom_range(0, 7);
      bit_sel = $urandom_range(0, 7);
      f[n][bit_sel] = ~f[n][bit_sel];
      n = FRAME_BYTES;
    end else if (kind == 2) begin
      n = $urandom_range(1, 7);
    end
    for (int k = 0; k < n; k++) send_rx(f[k], 0, STATUS_NONE);
    sent += n;
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             pending_results.size());
    $display("Verification failed");
    $finish;
  end

  // receiver: randomly chosen stall patterns, plus long hold-offs
  initial begin
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc == 3000 || cyc == 9000) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        cyc += 400;
      end
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          out_ready_i <= 1'b1;
        end
        1: begin
          out_ready_i <= 1'($urandom_range(0, 1));
        end
        2: begin
          out_ready_i <= (cyc % 4 == 0);
        end
        default: begin
          out_ready_i <= ($urandom_range(0, 9) != 0);
        end
      endcase
    end
  end

  // result check, start byte tracking and prediction at each transfer
  always @(posedge clk_i) begin
    frame_result_t w;
    frame_result_t p;
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result status", status_o, 0);
      end else begin
        w = pending_results.pop_front();
        if (w.status == STATUS_FRAME) frames_passed++;
        if (w.status == STATUS_REJECT) frames_rejected++;
        if (status_o != w.status) report_mismatch("status", status_o, w.status);
        if (command_o != w.command) report_mismatch("command", command_o, w.command);
        if (payload0_o != w.payload0) report_mismatch("payload0", payload0_o, w.payload0);
        if (payload1_o != w.payload1) report_mismatch("payload1", payload1_o, w.payload1);
        if (payload2_o != w.payload2) report_mismatch("payload2", payload2_o, w.payload2);
        if (payload3_o != w.payload3) report_mismatch("payload3", payload3_o, w.payload3);
        if (check_value_o != w.check_value) begin
          report_mismatch("check_value", check_value_o, w.check_value);
        end
      end
    end
    if (cfg_valid_i && cfg_ready_o) start_model = cfg_data_i;
    if (in_valid_i && in_ready_o) begin
      p = parse_byte(rx_byte_i);
      if (row_typed) begin
        p = '0;
        p.status = row_status;
      end
      pending_results.push_back(p);
    end
  end

  // stimulus
  initial begin
    logic [7:0] phase_start [6];
    int         sent;
    int         pick;
    int         noise;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = 8'h00;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'h00;
    row_typed   = 1'b0;
    row_status  = STATUS_NONE;
    start_model = START_RESET;
    held_count  = 0;
    burst_left  = 0;
    for (int k = 0; k < FRAME_BYTES; k++) held_bytes[k] = 8'h00;
    load_directed_table();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) write_start(directed_rows[i].data);
      else send_rx(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
    end

    // random phases, each under its own start byte
    phase_start = '{8'h00, 8'hFF, START_RESET, 8'h55, 8'h00, 8'h00};
    phase_start[4] = 8'($urandom_range(0, 255));
    phase_start[5] = 8'($urandom_range(0, 255));
    foreach (phase_start[ph]) begin
      write_start(phase_start[ph]);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_frame(phase_start[ph], 0, sent);
        end else if (pick < 80) begin
          send_frame(phase_start[ph], 1, sent);
        end else if (pick < 88) begin
          send_frame(phase_start[ph], 2, sent);
        end else begin
          noise = $urandom_range(1, 6);
          repeat (noise) begin
            send_rx(($urandom_range(0, 4) == 0) ? phase_start[ph]
                                                : 8'($urandom_range(0, 255)),
                    0, STATUS_NONE);
          end
          sent += noise;
        end
      end
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("sent %0d bytes under %0d start byte settings", bytes_sent, start_writes);
    $display("checked %0d results: %0d good frames, %0d rejected frames", results_seen,
             frames_passed, frames_rejected);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/cfpr_pkg.sv
src/cfpr_crc.sv
src/crc_frame_parser_resync.sv
test/tb.sv
